### hw/rtl/chm_pkg.sv
// constants, codes and types shared by the chained hash map
package chm_pkg;

  // geometry
  localparam int BUCKETS          = 64;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;
  localparam int BKT_W            = $clog2(BUCKETS);
  localparam int IDX_W            = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FILL_W           = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ADDR_W           = $clog2(TOTAL_SLOTS);

  // field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int HASH_W = 32;
  localparam int STAT_W = 2;

  typedef logic [BKT_W-1:0]  bucket_t;
  typedef logic [IDX_W-1:0]  slot_idx_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ADDR_W-1:0] slot_addr_t;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // request sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_COMMIT
  } state_t;

  // flat slot address of a slot within a bucket
  function automatic slot_addr_t slot_addr(input bucket_t b, input slot_idx_t i);
    logic [ADDR_W+IDX_W:0] sum;
    begin
      sum = (ADDR_W + IDX_W + 1)'(b) * (ADDR_W + IDX_W + 1)'(SLOTS_PER_BUCKET)
          + (ADDR_W + IDX_W + 1)'(i);
      slot_addr = sum[ADDR_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/chained_hash_map.sv
// chained hash map: bucket fill memory, slot memory and scan sequencer
// a request goes S_FILL, S_SCAN (0 to 8 filled slots, up to a key match), S_COMMIT
// one request at a time, taken in S_IDLE; the slot memory port compares one slot a cycle
// next request is taken while a finished result still waits on the output register
// reset: synchronous, clears the sequencer, output valid, missing value and bucket fill
// valid bits; slot contents are undefined until written and need no clearing
module chained_hash_map (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,    // missing_value
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // key[31:0], key_hash[63:32], value[95:64]
  input  logic         s_axis_tuser,   // cmd
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // read_value
  output logic [1:0]   m_axis_tuser    // status
);

  chm_pkg::state_t state, state_next;

  // configuration register
  logic [chm_pkg::VAL_W-1:0] missing_value;

  // latched request
  logic                       cmd_q;
  logic [chm_pkg::KEY_W-1:0]  key_q;
  logic [chm_pkg::VAL_W-1:0]  value_q;
  chm_pkg::bucket_t           bucket_q;

  // scan state
  chm_pkg::fill_t             fill_count;
  chm_pkg::slot_idx_t         scan_idx;
  chm_pkg::slot_idx_t         scan_rd_idx;
  logic                       hit;
  chm_pkg::slot_idx_t         hit_idx;
  logic [chm_pkg::VAL_W-1:0]  found_value;

  // memories
  chm_pkg::fill_t             fill_mem [chm_pkg::BUCKETS];
  logic [chm_pkg::BUCKETS-1:0] fill_vld;
  chm_pkg::fill_t             fill_rd;
  logic                       fill_rd_vld;
  chm_pkg::fill_t             fill_cur;
  chm_pkg::bucket_t           fill_rd_addr;
  logic                       fill_we;

  logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] slot_mem [chm_pkg::TOTAL_SLOTS];
  logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] slot_rd;
  chm_pkg::slot_addr_t        slot_rd_addr;
  chm_pkg::slot_addr_t        slot_wr_addr;
  logic                       slot_we;

  // handshake and control
  logic                       in_beat;
  logic                       commit_go;
  logic                       slot_match;
  logic                       scan_last;
  logic                       set_full;
  logic [chm_pkg::VAL_W-1:0]  res_value;
  logic [chm_pkg::STAT_W-1:0] res_status;

  // input and output handshake decode
  always_comb begin
    s_axis_tready = (state == chm_pkg::S_IDLE);
    in_beat       = s_axis_tvalid && s_axis_tready;
    commit_go     = (state == chm_pkg::S_COMMIT) && (!m_axis_tvalid || m_axis_tready);
  end

  // scan compare
  always_comb begin
    slot_match = (slot_rd[chm_pkg::KEY_W+chm_pkg::VAL_W-1:chm_pkg::VAL_W] == key_q);
    scan_last  = ((chm_pkg::FILL_W)'(scan_idx) + 1'b1) == fill_count;
    set_full   = (fill_count == (chm_pkg::FILL_W)'(chm_pkg::SLOTS_PER_BUCKET));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      chm_pkg::S_IDLE: begin
        if (in_beat) state_next = chm_pkg::S_FILL;
      end
      chm_pkg::S_FILL: begin
        if (fill_cur == '0) state_next = chm_pkg::S_COMMIT;
        else                state_next = chm_pkg::S_SCAN;
      end
      chm_pkg::S_SCAN: begin
        if (slot_match || scan_last) state_next = chm_pkg::S_COMMIT;
      end
      chm_pkg::S_COMMIT: begin
        if (commit_go) state_next = chm_pkg::S_IDLE;
      end
      default: state_next = chm_pkg::S_IDLE;
    endcase
  end

  // memory addressing and write strobes
  always_comb begin
    fill_cur     = fill_rd_vld ? fill_rd : '0;
    fill_rd_addr = s_axis_tdata[chm_pkg::KEY_W +: chm_pkg::BKT_W];
    scan_rd_idx  = (state == chm_pkg::S_SCAN) ? scan_idx + 1'b1 : '0;
    slot_rd_addr = chm_pkg::slot_addr(bucket_q, scan_rd_idx);
    slot_wr_addr = chm_pkg::slot_addr(bucket_q,
                     hit ? hit_idx : fill_count[chm_pkg::IDX_W-1:0]);
    slot_we      = commit_go && (cmd_q == chm_pkg::CMD_SET) && (hit || !set_full);
    fill_we      = commit_go && (cmd_q == chm_pkg::CMD_SET) && !hit && !set_full;
  end

  // result of the request
  always_comb begin
    res_value  = '0;
    res_status = chm_pkg::ST_OK;
    if (cmd_q == chm_pkg::CMD_GET) begin
      if (hit) begin
        res_value = found_value;
      end else begin
        res_value  = missing_value;
        res_status = chm_pkg::ST_NOT_FOUND;
      end
    end else if (!hit && set_full) begin
      res_status = chm_pkg::ST_FULL;
    end
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= chm_pkg::S_IDLE;
      m_axis_tvalid <= 1'b0;
      missing_value <= '0;
      fill_vld      <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) missing_value <= cfg_wr_data;
      if (commit_go)          m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (fill_we) fill_vld[bucket_q] <= 1'b1;
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q    <= s_axis_tuser;
      key_q    <= s_axis_tdata[chm_pkg::KEY_W-1:0];
      bucket_q <= fill_rd_addr;
      value_q  <= s_axis_tdata[chm_pkg::KEY_W+chm_pkg::HASH_W +: chm_pkg::VAL_W];
    end
    if (state == chm_pkg::S_FILL) begin
      fill_count <= fill_cur;
      scan_idx   <= '0;
      hit        <= 1'b0;
    end
    if (state == chm_pkg::S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (slot_match) begin
        hit         <= 1'b1;
        hit_idx     <= scan_idx;
        found_value <= slot_rd[chm_pkg::VAL_W-1:0];
      end
    end
    if (commit_go) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_status;
    end
  end

  // bucket fill memory
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[bucket_q] <= fill_count + 1'b1;
    fill_rd     <= fill_mem[fill_rd_addr];
    fill_rd_vld <= fill_vld[fill_rd_addr];
  end

  // slot memory, key in the upper half
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wr_addr] <= {key_q, value_q};
    slot_rd <= slot_mem[slot_rd_addr];
  end

endmodule
